>>> design/kchp_pkg.sv
// ----------------------------------------------------------------------------
// kchp_pkg
// Shared types and codes for the keyer host command parser.
// ----------------------------------------------------------------------------
package kchp_pkg;

    localparam int SETTINGS_BYTES_DEF = 15;
    localparam int MEMORY_BYTES_DEF   = 256;

    localparam logic [7:0] XOFF_THRESHOLD_RST = 8'd42;

    localparam logic [7:0] CMD_LAST_CODE = 8'h17;
    localparam logic [7:0] REPLY_STATUS  = 8'hC0;
    localparam logic [7:0] REPLY_VERSION = 8'h10;
    localparam logic [7:0] REPLY_ADMIN2  = 8'h16;
    localparam logic [7:0] REPLY_ADMIN15 = 8'h52;
    localparam logic [7:0] CALIB_END     = 8'hFF;

    localparam logic [7:0] CMD_ADMIN     = 8'h00;
    localparam logic [7:0] CMD_SPEED     = 8'h02;
    localparam logic [7:0] CMD_PTT       = 8'h04;
    localparam logic [7:0] CMD_POT       = 8'h05;
    localparam logic [7:0] CMD_VERSION   = 8'h07;
    localparam logic [7:0] CMD_NOP_A     = 8'h08;
    localparam logic [7:0] CMD_CLEAR     = 8'h0A;
    localparam logic [7:0] CMD_KEYMODE   = 8'h0E;
    localparam logic [7:0] CMD_LOADSET   = 8'h0F;
    localparam logic [7:0] CMD_NOP_B     = 8'h13;
    localparam logic [7:0] CMD_PADDLE    = 8'h14;
    localparam logic [7:0] CMD_STATUS    = 8'h15;

    localparam logic [7:0] ADM_CALIB     = 8'h00;
    localparam logic [7:0] ADM_RESET     = 8'h01;
    localparam logic [7:0] ADM_ID        = 8'h02;
    localparam logic [7:0] ADM_ECHO      = 8'h04;
    localparam logic [7:0] ADM_ZERO_A    = 8'h05;
    localparam logic [7:0] ADM_ZERO_B    = 8'h06;
    localparam logic [7:0] ADM_ZERO_C    = 8'h07;
    localparam logic [7:0] ADM_ZERO_D    = 8'h08;
    localparam logic [7:0] ADM_ZERO_E    = 8'h09;
    localparam logic [7:0] ADM_DUMP      = 8'h0C;
    localparam logic [7:0] ADM_LOADMEM   = 8'h0D;
    localparam logic [7:0] ADM_VERSION   = 8'h15;

    localparam logic [7:0] PADDLE_DIT    = 8'h01;
    localparam logic [7:0] PADDLE_DAH    = 8'h02;

    localparam logic [3:0] ST_IDLE    = 4'd0;
    localparam logic [3:0] ST_ADMIN   = 4'd1;
    localparam logic [3:0] ST_SKIP    = 4'd2;
    localparam logic [3:0] ST_SPEED   = 4'd3;
    localparam logic [3:0] ST_KEYMODE = 4'd4;
    localparam logic [3:0] ST_PADDLE  = 4'd5;
    localparam logic [3:0] ST_LOADSET = 4'd6;
    localparam logic [3:0] ST_LOADMEM = 4'd7;
    localparam logic [3:0] ST_ECHO    = 4'd8;
    localparam logic [3:0] ST_CALIB   = 4'd9;

    localparam logic [3:0] ACT_NONE  = 4'd0;
    localparam logic [3:0] ACT_QUEUE = 4'd1;
    localparam logic [3:0] ACT_REPLY = 4'd2;
    localparam logic [3:0] ACT_SPEED = 4'd3;
    localparam logic [3:0] ACT_MODE  = 4'd4;
    localparam logic [3:0] ACT_STORE = 4'd5;
    localparam logic [3:0] ACT_CLEAR = 4'd6;
    localparam logic [3:0] ACT_DIT   = 4'd7;
    localparam logic [3:0] ACT_DAH   = 4'd8;
    localparam logic [3:0] ACT_DUMP  = 4'd9;
    localparam logic [3:0] ACT_MEMWR = 4'd10;
    localparam logic [3:0] ACT_RESET = 4'd11;

    localparam logic [7:0] SETTING_KEYMODE = 8'd0;
    localparam logic [7:0] SETTING_SPEED   = 8'd1;

    typedef struct packed {
        logic [3:0] state;
        logic [3:0] args_left;
        logic [7:0] mem_ptr;
    } t_parse;

    typedef struct packed {
        logic [3:0] action;
        logic [7:0] value;
        logic [7:0] index;
        logic       save_settings;
    } t_result;

endpackage

>>> design/keyer_host_command_parser.sv
// ----------------------------------------------------------------------------
// keyer_host_command_parser
// Host byte stream parser of a Morse keyer with a registered result.
// ----------------------------------------------------------------------------
// Each accepted host byte produces exactly one result in the output register
// in the next cycle, and the parser takes a new byte in every cycle as long as
// that register is empty or its result is taken in the same cycle, so the
// sustained rate is one byte per clock, set by the single decode pass between
// the parser state registers and the result register. The xoff threshold is
// written through the always ready configuration channel; the user must write
// it only while no transaction is in flight, which the block does not enforce.
module keyer_host_command_parser import kchp_pkg::*; #(
    parameter int SETTINGS_BYTES = SETTINGS_BYTES_DEF,
    parameter int MEMORY_BYTES   = MEMORY_BYTES_DEF
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_cfg_valid,
    output logic       o_cfg_ready,
    input  logic [7:0] i_cfg_xoff_threshold,
    input  logic       i_in_valid,
    output logic       o_in_ready,
    input  logic [7:0] i_rx_byte,
    input  logic [7:0] i_key_buffer_free,
    output logic       o_out_valid,
    input  logic       i_out_ready,
    output logic [3:0] o_action,
    output logic [7:0] o_value,
    output logic [7:0] o_index,
    output logic       o_save_settings
);

    t_parse     r_parse;
    t_parse     n_parse;
    t_result    r_res;
    t_result    n_res;
    logic       r_out_valid;
    logic [7:0] r_xoff;
    logic       w_accept;

    assign o_cfg_ready = 1'b1;
    assign o_in_ready  = !r_out_valid || i_out_ready;
    assign w_accept    = i_in_valid && o_in_ready;

    kchp_decode #(
        .SETTINGS_BYTES (SETTINGS_BYTES),
        .MEMORY_BYTES   (MEMORY_BYTES)
    ) u_decode (
        .i_cur             (r_parse),
        .i_rx_byte         (i_rx_byte),
        .i_key_buffer_free (i_key_buffer_free),
        .i_xoff_threshold  (r_xoff),
        .o_nxt             (n_parse),
        .o_res             (n_res)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_parse     <= '{state: ST_IDLE, args_left: 4'd0, mem_ptr: 8'd0};
            r_out_valid <= 1'b0;
            r_xoff      <= XOFF_THRESHOLD_RST;
        end else begin
            if (i_cfg_valid) begin
                r_xoff <= i_cfg_xoff_threshold;
            end
            if (w_accept) begin
                r_parse     <= n_parse;
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_res <= n_res;
        end
    end

    assign o_out_valid     = r_out_valid;
    assign o_action        = r_res.action;
    assign o_value         = r_res.value;
    assign o_index         = r_res.index;
    assign o_save_settings = r_res.save_settings;

endmodule

>>> design/kchp_decode.sv
// ----------------------------------------------------------------------------
// kchp_decode
// Next-state and result decode for one host byte.
// ----------------------------------------------------------------------------
module kchp_decode import kchp_pkg::*; #(
    parameter int SETTINGS_BYTES = SETTINGS_BYTES_DEF,
    parameter int MEMORY_BYTES   = MEMORY_BYTES_DEF
) (
    input  t_parse     i_cur,
    input  logic [7:0] i_rx_byte,
    input  logic [7:0] i_key_buffer_free,
    input  logic [7:0] i_xoff_threshold,
    output t_parse     o_nxt,
    output t_result    o_res
);

    localparam logic [3:0] LP_SET_ARGS = 4'(SETTINGS_BYTES);
    localparam logic [7:0] LP_SET_SIZE = 8'(SETTINGS_BYTES);
    localparam logic [8:0] LP_MEM_SIZE = 9'(MEMORY_BYTES);

    logic [3:0] w_args_dec;
    logic [8:0] w_ptr_inc;

    assign w_args_dec = i_cur.args_left - 4'd1;
    assign w_ptr_inc  = {1'b0, i_cur.mem_ptr} + 9'd1;

    always_comb begin
        o_nxt = i_cur;
        o_res = '{action: ACT_NONE, value: 8'd0, index: 8'd0, save_settings: 1'b0};
        case (i_cur.state)
            ST_IDLE: begin
                if (i_rx_byte > CMD_LAST_CODE) begin
                    if (i_key_buffer_free == 8'd0) begin
                        o_res.action = ACT_REPLY;
                        o_res.value  = REPLY_STATUS;
                    end else begin
                        o_res.action = ACT_QUEUE;
                        o_res.value  = i_rx_byte;
                    end
                end else begin
                    case (i_rx_byte)
                        CMD_ADMIN:   o_nxt.state = ST_ADMIN;
                        CMD_SPEED:   o_nxt.state = ST_SPEED;
                        CMD_PTT: begin
                            o_nxt.state     = ST_SKIP;
                            o_nxt.args_left = 4'd2;
                        end
                        CMD_POT: begin
                            o_nxt.state     = ST_SKIP;
                            o_nxt.args_left = 4'd3;
                        end
                        CMD_VERSION: begin
                            o_res.action = ACT_REPLY;
                            o_res.value  = REPLY_VERSION;
                        end
                        CMD_NOP_A, CMD_NOP_B: ;
                        CMD_CLEAR:   o_res.action = ACT_CLEAR;
                        CMD_KEYMODE: o_nxt.state = ST_KEYMODE;
                        CMD_LOADSET: begin
                            o_nxt.state     = ST_LOADSET;
                            o_nxt.args_left = LP_SET_ARGS;
                        end
                        CMD_PADDLE:  o_nxt.state = ST_PADDLE;
                        CMD_STATUS: begin
                            o_res.action = ACT_REPLY;
                            o_res.value  = REPLY_STATUS
                                | {7'd0, i_key_buffer_free < i_xoff_threshold};
                        end
                        default: begin
                            o_nxt.state     = ST_SKIP;
                            o_nxt.args_left = 4'd1;
                        end
                    endcase
                end
            end
            ST_ADMIN: begin
                o_nxt.state = ST_IDLE;
                case (i_rx_byte)
                    ADM_CALIB: o_nxt.state = ST_CALIB;
                    ADM_RESET: o_res.action = ACT_RESET;
                    ADM_ID: begin
                        o_res.action = ACT_REPLY;
                        o_res.value  = REPLY_ADMIN2;
                    end
                    ADM_ECHO: o_nxt.state = ST_ECHO;
                    ADM_ZERO_A, ADM_ZERO_B, ADM_ZERO_C, ADM_ZERO_D, ADM_ZERO_E:
                        o_res.action = ACT_REPLY;
                    ADM_DUMP: o_res.action = ACT_DUMP;
                    ADM_LOADMEM: begin
                        o_nxt.state   = ST_LOADMEM;
                        o_nxt.mem_ptr = 8'd0;
                    end
                    ADM_VERSION: begin
                        o_res.action = ACT_REPLY;
                        o_res.value  = REPLY_ADMIN15;
                    end
                    default: ;
                endcase
            end
            ST_SKIP: begin
                if (i_cur.args_left <= 4'd1) begin
                    o_nxt.args_left = 4'd0;
                    o_nxt.state     = ST_IDLE;
                end else begin
                    o_nxt.args_left = w_args_dec;
                end
            end
            ST_SPEED: begin
                o_res = '{action: ACT_SPEED, value: i_rx_byte, index: SETTING_SPEED,
                          save_settings: 1'b1};
                o_nxt.state = ST_IDLE;
            end
            ST_KEYMODE: begin
                o_res = '{action: ACT_MODE, value: i_rx_byte, index: SETTING_KEYMODE,
                          save_settings: 1'b1};
                o_nxt.state = ST_IDLE;
            end
            ST_PADDLE: begin
                if (i_rx_byte == PADDLE_DIT) begin
                    o_res.action = ACT_DIT;
                end else if (i_rx_byte == PADDLE_DAH) begin
                    o_res.action = ACT_DAH;
                end
                o_nxt.state = ST_IDLE;
            end
            ST_LOADSET: begin
                if (i_cur.args_left == 4'd0 || i_cur.args_left > LP_SET_ARGS) begin
                    o_nxt.args_left = 4'd0;
                    o_nxt.state     = ST_IDLE;
                end else begin
                    o_res.action    = ACT_STORE;
                    o_res.value     = i_rx_byte;
                    o_res.index     = LP_SET_SIZE - {4'd0, i_cur.args_left};
                    o_nxt.args_left = w_args_dec;
                    if (w_args_dec == 4'd0) begin
                        o_res.save_settings = 1'b1;
                        o_nxt.state         = ST_IDLE;
                    end
                end
            end
            ST_LOADMEM: begin
                o_res.action  = ACT_MEMWR;
                o_res.value   = i_rx_byte;
                o_res.index   = i_cur.mem_ptr;
                if (w_ptr_inc >= LP_MEM_SIZE) begin
                    o_nxt.state = ST_IDLE;
                end
                o_nxt.mem_ptr = w_ptr_inc[7:0];
            end
            ST_ECHO: begin
                o_res.action = ACT_REPLY;
                o_res.value  = i_rx_byte;
                o_nxt.state  = ST_IDLE;
            end
            ST_CALIB: begin
                if (i_rx_byte == CALIB_END) begin
                    o_nxt.state = ST_IDLE;
                end
            end
            default: begin
                o_nxt.state     = ST_IDLE;
                o_nxt.args_left = 4'd0;
            end
        endcase
    end

endmodule

>>> design/kchp_checker.sv
// ----------------------------------------------------------------------------
// kchp_checker
// Port-level checks for the keyer host command parser.
// ----------------------------------------------------------------------------
module kchp_checker import kchp_pkg::*; (
    input logic       i_clk,
    input logic       i_rst_n,
    input logic       i_in_valid,
    input logic       o_in_ready,
    input logic       o_out_valid,
    input logic       i_out_ready,
    input logic [3:0] o_action,
    input logic [7:0] o_value,
    input logic       o_save_settings
);

    a_result_follows: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_in_valid && o_in_ready |=> o_out_valid)
        else $error("Accepted byte produced no result.");

    a_result_held: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !i_out_ready |=> o_out_valid && $stable(o_action)
            && $stable(o_value))
        else $error("Stalled result changed or vanished.");

    a_action_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> o_action <= ACT_RESET)
        else $error("Result action code out of range.");

    a_save_kind: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_save_settings |->
            o_action == ACT_SPEED || o_action == ACT_MODE || o_action == ACT_STORE)
        else $error("Save flag raised with a non-settings action.");

    a_queue_text: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_action == ACT_QUEUE |-> o_value > CMD_LAST_CODE)
        else $error("Command byte queued as text.");

endmodule

bind keyer_host_command_parser kchp_checker u_kchp_checker (
    .i_clk           (i_clk),
    .i_rst_n         (i_rst_n),
    .i_in_valid      (i_in_valid),
    .o_in_ready      (o_in_ready),
    .o_out_valid     (o_out_valid),
    .i_out_ready     (i_out_ready),
    .o_action        (o_action),
    .o_value         (o_value),
    .o_save_settings (o_save_settings)
);

>>> dv/keyer_host_command_parser_test.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// keyer_host_command_parser_test
// Self-checking testbench for the keyer host command parser.
// ----------------------------------------------------------------------------
// A short table of host bytes covers each command but the settings load, the
// admin subcommands but the memory load and four zero replies, and the corner
// cases of text, status and argument handling. Random command sequences follow
// in several phases, each with its own xoff threshold. Results are checked
// against the table or a cycle-free model, with random stalls in some phases.
// ----------------------------------------------------------------------------
module keyer_host_command_parser_test;
    import kchp_pkg::*;

    localparam int RANDOM_ITEMS   = 1400;
    localparam int HOLD_CYCLES    = 80;
    localparam int WATCHDOG_LIMIT = 1000;
    localparam int PHASES         = 6;

    typedef enum {
        SEQ_TEXT, SEQ_STATUS, SEQ_SIMPLE, SEQ_SPEED, SEQ_KEYMODE, SEQ_PADDLE,
        SEQ_SKIP, SEQ_LOADSET, SEQ_LOADSET_CUT, SEQ_ADMIN, SEQ_LOADMEM, SEQ_NOISE
    } t_seq_kind;

    typedef struct {
        logic [7:0] rx;
        logic [7:0] free_slots;
        bit         typed;
        t_result    res;
    } t_host_row;

    logic       i_clk = 1'b0;
    logic       i_rst_n;
    logic       i_cfg_valid;
    logic       o_cfg_ready;
    logic [7:0] i_cfg_xoff_threshold;
    logic       i_in_valid;
    logic       o_in_ready;
    logic [7:0] i_rx_byte;
    logic [7:0] i_key_buffer_free;
    logic       o_out_valid;
    logic       i_out_ready;
    logic [3:0] o_action;
    logic [7:0] o_value;
    logic [7:0] o_index;
    logic       o_save_settings;

    logic [3:0] parse_st;
    logic [3:0] arg_count;
    logic [7:0] mem_addr;
    logic [7:0] setting_bytes [SETTINGS_BYTES_DEF];
    logic [7:0] xoff_level;

    t_result   pending_results [$];
    t_host_row directed_rows [$];

    int  items_sent = 0;
    int  results_seen = 0;
    int  error_count = 0;
    int  cfg_writes = 0;
    int  quiet_cycles = 0;
    int  action_hits [16];
    bit  sender_gaps = 1'b1;
    bit  sink_stalls = 1'b1;
    bit  long_hold_request = 1'b0;
    bit  long_hold_on = 1'b0;

    always #6 i_clk = ~i_clk;

    keyer_host_command_parser dut (
        .i_clk                (i_clk),
        .i_rst_n              (i_rst_n),
        .i_cfg_valid          (i_cfg_valid),
        .o_cfg_ready          (o_cfg_ready),
        .i_cfg_xoff_threshold (i_cfg_xoff_threshold),
        .i_in_valid           (i_in_valid),
        .o_in_ready           (o_in_ready),
        .i_rx_byte            (i_rx_byte),
        .i_key_buffer_free    (i_key_buffer_free),
        .o_out_valid          (o_out_valid),
        .i_out_ready          (i_out_ready),
        .o_action             (o_action),
        .o_value              (o_value),
        .o_index              (o_index),
        .o_save_settings      (o_save_settings)
    );

    function automatic t_result decode_host_byte(input logic [7:0] b, input logic [7:0] fr);
        t_result r;
        int      slot;
        r = '0;
        case (parse_st)
            ST_IDLE: begin
                if (b > CMD_LAST_CODE) begin
                    if (fr == 8'd0) begin
                        r.action = ACT_REPLY;
                        r.value  = REPLY_STATUS;
                    end else begin
                        r.action = ACT_QUEUE;
                        r.value  = b;
                    end
                end else begin
                    case (b)
                        CMD_ADMIN:   parse_st = ST_ADMIN;
                        CMD_SPEED:   parse_st = ST_SPEED;
                        CMD_PTT: begin
                            parse_st  = ST_SKIP;
                            arg_count = 4'd2;
                        end
                        CMD_POT: begin
                            parse_st  = ST_SKIP;
                            arg_count = 4'd3;
                        end
                        CMD_VERSION: begin
                            r.action = ACT_REPLY;
                            r.value  = REPLY_VERSION;
                        end
                        CMD_NOP_A, CMD_NOP_B: ;
                        CMD_CLEAR:   r.action = ACT_CLEAR;
                        CMD_KEYMODE: parse_st = ST_KEYMODE;
                        CMD_LOADSET: begin
                            parse_st  = ST_LOADSET;
                            arg_count = 4'(SETTINGS_BYTES_DEF);
                        end
                        CMD_PADDLE:  parse_st = ST_PADDLE;
                        CMD_STATUS: begin
                            r.action = ACT_REPLY;
                            r.value  = REPLY_STATUS | {7'd0, fr < xoff_level};
                        end
                        default: begin
                            parse_st  = ST_SKIP;
                            arg_count = 4'd1;
                        end
                    endcase
                end
            end
            ST_ADMIN: begin
                parse_st = ST_IDLE;
                case (b)
                    ADM_CALIB:   parse_st = ST_CALIB;
                    ADM_RESET:   r.action = ACT_RESET;
                    ADM_ID: begin
                        r.action = ACT_REPLY;
                        r.value  = REPLY_ADMIN2;
                    end
                    ADM_ECHO:    parse_st = ST_ECHO;
                    ADM_ZERO_A, ADM_ZERO_B, ADM_ZERO_C, ADM_ZERO_D, ADM_ZERO_E:
                        r.action = ACT_REPLY;
                    ADM_DUMP:    r.action = ACT_DUMP;
                    ADM_LOADMEM: begin
                        parse_st = ST_LOADMEM;
                        mem_addr = 8'd0;
                    end
                    ADM_VERSION: begin
                        r.action = ACT_REPLY;
                        r.value  = REPLY_ADMIN15;
                    end
                    default: ;
                endcase
            end
            ST_SKIP: begin
                if (arg_count <= 4'd1) begin
                    arg_count = 4'd0;
                    parse_st  = ST_IDLE;
                end else begin
                    arg_count = arg_count - 4'd1;
                end
            end
            ST_SPEED: begin
                setting_bytes[SETTING_SPEED] = b;
                r        = {ACT_SPEED, b, SETTING_SPEED, 1'b1};
                parse_st = ST_IDLE;
            end
            ST_KEYMODE: begin
                setting_bytes[SETTING_KEYMODE] = b;
                r        = {ACT_MODE, b, SETTING_KEYMODE, 1'b1};
                parse_st = ST_IDLE;
            end
            ST_PADDLE: begin
                if (b == PADDLE_DIT) begin
                    r.action = ACT_DIT;
                end else if (b == PADDLE_DAH) begin
                    r.action = ACT_DAH;
                end
                parse_st = ST_IDLE;
            end
            ST_LOADSET: begin
                if (arg_count == 4'd0 || int'(arg_count) > SETTINGS_BYTES_DEF) begin
                    arg_count = 4'd0;
                    parse_st  = ST_IDLE;
                end else begin
                    slot = SETTINGS_BYTES_DEF - int'(arg_count);
                    setting_bytes[slot] = b;
                    r.action  = ACT_STORE;
                    r.value   = b;
                    r.index   = 8'(slot);
                    arg_count = arg_count - 4'd1;
                    if (arg_count == 4'd0) begin
                        r.save_settings = 1'b1;
                        parse_st = ST_IDLE;
                    end
                end
            end
            ST_LOADMEM: begin
                r = {ACT_MEMWR, b, mem_addr, 1'b0};
                if (int'(mem_addr) + 1 >= MEMORY_BYTES_DEF) begin
                    parse_st = ST_IDLE;
                end
                mem_addr = mem_addr + 8'd1;
            end
            ST_ECHO: begin
                r.action = ACT_REPLY;
                r.value  = b;
                parse_st = ST_IDLE;
            end
            ST_CALIB: begin
                if (b == CALIB_END) begin
                    parse_st = ST_IDLE;
                end
            end
            default: begin
                parse_st  = ST_IDLE;
                arg_count = 4'd0;
            end
        endcase
        return r;
    endfunction

    function automatic bit takes_one_arg(input logic [7:0] code);
        case (code)
            CMD_ADMIN, CMD_SPEED, CMD_PTT, CMD_POT, CMD_VERSION, CMD_NOP_A, CMD_CLEAR,
            CMD_KEYMODE, CMD_LOADSET, CMD_NOP_B, CMD_PADDLE, CMD_STATUS: return 1'b0;
            default: return 1'b1;
        endcase
    endfunction

    function automatic logic [7:0] pick_free();
        case ($urandom_range(0, 7))
            0: return 8'd0;
            1: return xoff_level + 8'($urandom_range(0, 2)) - 8'd1;
            default: return 8'($urandom_range(0, 255));
        endcase
    endfunction

    task automatic add_row(input logic [7:0] rx, input logic [7:0] fr, input bit typed,
                           input t_result res);
        t_host_row row;
        row.rx         = rx;
        row.free_slots = fr;
        row.typed      = typed;
        row.res        = res;
        directed_rows.push_back(row);
    endtask

    task automatic send_byte(input logic [7:0] rx, input logic [7:0] fr, input bit typed,
                             input t_result res);
        t_result guess;
        if (sender_gaps && !long_hold_on && $urandom_range(0, 11) == 0) begin
            i_in_valid <= 1'b0;
            repeat ($urandom_range(1, 18)) @(posedge i_clk);
        end
        i_in_valid        <= 1'b1;
        i_rx_byte         <= rx;
        i_key_buffer_free <= fr;
        @(posedge i_clk);
        while (!o_in_ready) @(posedge i_clk);
        guess = decode_host_byte(rx, fr);
        pending_results.push_back(typed ? res : guess);
        items_sent++;
    endtask

    task automatic send_sequence(input t_seq_kind kind);
        int         n;
        int         k;
        logic [7:0] b;
        case (kind)
            SEQ_TEXT: begin
                n = $urandom_range(1, 6);
                for (k = 0; k < n; k++) begin
                    b = 8'($urandom_range(int'(CMD_LAST_CODE) + 1, 255));
                    send_byte(b, pick_free(), 1'b0, '0);
                end
            end
            SEQ_STATUS: send_byte(CMD_STATUS, pick_free(), 1'b0, '0);
            SEQ_SIMPLE: begin
                case ($urandom_range(0, 3))
                    0: b = CMD_VERSION;
                    1: b = CMD_CLEAR;
                    2: b = CMD_NOP_A;
                    default: b = CMD_NOP_B;
                endcase
                send_byte(b, pick_free(), 1'b0, '0);
            end
            SEQ_SPEED, SEQ_KEYMODE: begin
                send_byte(kind == SEQ_SPEED ? CMD_SPEED : CMD_KEYMODE, pick_free(), 1'b0, '0);
                send_byte(8'($urandom), pick_free(), 1'b0, '0);
            end
            SEQ_PADDLE: begin
                send_byte(CMD_PADDLE, pick_free(), 1'b0, '0);
                case ($urandom_range(0, 2))
                    0: b = PADDLE_DIT;
                    1: b = PADDLE_DAH;
                    default: b = 8'($urandom);
                endcase
                send_byte(b, pick_free(), 1'b0, '0);
            end
            SEQ_SKIP: begin
                case ($urandom_range(0, 2))
                    0: begin
                        b = CMD_PTT;
                        n = 2;
                    end
                    1: begin
                        b = CMD_POT;
                        n = 3;
                    end
                    default: begin
                        b = 8'($urandom_range(0, CMD_LAST_CODE));
                        while (!takes_one_arg(b)) b = 8'($urandom_range(0, CMD_LAST_CODE));
                        n = 1;
                    end
                endcase
                send_byte(b, pick_free(), 1'b0, '0);
                for (k = 0; k < n; k++) begin
                    send_byte(8'($urandom), pick_free(), 1'b0, '0);
                end
            end
            SEQ_LOADSET, SEQ_LOADSET_CUT: begin
                n = (kind == SEQ_LOADSET) ? SETTINGS_BYTES_DEF
                                          : $urandom_range(1, SETTINGS_BYTES_DEF - 1);
                send_byte(CMD_LOADSET, pick_free(), 1'b0, '0);
                for (k = 0; k < n; k++) begin
                    send_byte(8'($urandom), pick_free(), 1'b0, '0);
                end
            end
            SEQ_LOADMEM: begin
                send_byte(CMD_ADMIN, pick_free(), 1'b0, '0);
                send_byte(ADM_LOADMEM, pick_free(), 1'b0, '0);
                for (k = 0; k < MEMORY_BYTES_DEF; k++) begin
                    send_byte(8'($urandom), pick_free(), 1'b0, '0);
                end
            end
            SEQ_ADMIN: begin
                send_byte(CMD_ADMIN, pick_free(), 1'b0, '0);
                case ($urandom_range(0, 9))
                    0: send_byte(ADM_ID, pick_free(), 1'b0, '0);
                    1: send_byte(ADM_VERSION, pick_free(), 1'b0, '0);
                    2: send_byte(ADM_ZERO_A + 8'($urandom_range(0, 4)), pick_free(), 1'b0, '0);
                    3: send_byte(ADM_DUMP, pick_free(), 1'b0, '0);
                    4: send_byte(ADM_RESET, pick_free(), 1'b0, '0);
                    5, 6: begin
                        send_byte(ADM_ECHO, pick_free(), 1'b0, '0);
                        send_byte(8'($urandom), pick_free(), 1'b0, '0);
                    end
                    7, 8: begin
                        send_byte(ADM_CALIB, pick_free(), 1'b0, '0);
                        n = $urandom_range(0, 5);
                        for (k = 0; k < n; k++) begin
                            send_byte(8'($urandom_range(0, 254)), pick_free(), 1'b0, '0);
                        end
                        send_byte(CALIB_END, pick_free(), 1'b0, '0);
                    end
                    default: send_byte(8'($urandom), pick_free(), 1'b0, '0);
                endcase
            end
            default: begin
                n = $urandom_range(1, 4);
                for (k = 0; k < n; k++) begin
                    send_byte(8'($urandom), 8'($urandom), 1'b0, '0);
                end
            end
        endcase
    endtask

    // The register may only change while no transaction is in flight.
    task automatic set_xoff_threshold(input logic [7:0] thr);
        i_in_valid <= 1'b0;
        while (pending_results.size() != 0) @(posedge i_clk);
        repeat (2) @(posedge i_clk);
        i_cfg_valid          <= 1'b1;
        i_cfg_xoff_threshold <= thr;
        @(posedge i_clk);
        while (!o_cfg_ready) @(posedge i_clk);
        i_cfg_valid <= 1'b0;
        xoff_level = thr;
        cfg_writes++;
    endtask

    task automatic note_error(input string what, input t_result want, input t_result got);
        error_count++;
        if (error_count <= 10) begin
            $display("%0t ns %s: got action %0d value 0x%02h index 0x%02h save %0d",
                     $time, what, got.action, got.value, got.index, got.save_settings);
            $display("    expected action %0d value 0x%02h index 0x%02h save %0d",
                     want.action, want.value, want.index, want.save_settings);
        end
    endtask

    initial begin : result_sink
        i_out_ready <= 1'b0;
        @(posedge i_clk);
        while (!i_rst_n) @(posedge i_clk);
        forever begin
            if (long_hold_request) begin
                long_hold_request = 1'b0;
                long_hold_on      = 1'b1;
                i_out_ready <= 1'b0;
                repeat (HOLD_CYCLES) @(posedge i_clk);
                long_hold_on = 1'b0;
            end else if (sink_stalls && $urandom_range(0, 9) == 0) begin
                i_out_ready <= 1'b0;
                repeat ($urandom_range(1, 18)) @(posedge i_clk);
            end
            i_out_ready <= 1'b1;
            @(posedge i_clk);
        end
    end

    always @(posedge i_clk) begin : result_check
        t_result got;
        t_result want;
        if (i_rst_n && o_out_valid && i_out_ready) begin
            got = {o_action, o_value, o_index, o_save_settings};
            results_seen++;
            if (!$isunknown(got.action)) begin
                action_hits[got.action]++;
            end
            if (pending_results.size() == 0) begin
                note_error("unexpected result", '0, got);
            end else begin
                want = pending_results.pop_front();
                if (got.action !== want.action || got.value !== want.value ||
                    got.index !== want.index || got.save_settings !== want.save_settings) begin
                    note_error("mismatch", want, got);
                end
            end
        end
    end

    // Counts cycles without any transaction; the longest legal gap is the
    // receiver hold-off plus a sender idle burst.
    always @(posedge i_clk) begin
        if (!i_rst_n || (i_in_valid && o_in_ready) || (o_out_valid && i_out_ready) ||
            (i_cfg_valid && o_cfg_ready)) begin
            quiet_cycles = 0;
        end else begin
            quiet_cycles++;
            if (quiet_cycles >= WATCHDOG_LIMIT) begin
                $display("Watchdog: no transaction for %0d cycles, %0d results outstanding.",
                         quiet_cycles, pending_results.size());
                $display("keyer_host_command_parser_test: done, errors");
                $finish;
            end
        end
    end

    initial begin : stimulus
        int         phase;
        int         phase_goal;
        int         directed_count;
        int         roll;
        int         kinds;
        t_seq_kind  kind;
        logic [7:0] thr;

        i_rst_n              <= 1'b0;
        i_cfg_valid          <= 1'b0;
        i_cfg_xoff_threshold <= 8'd0;
        i_in_valid           <= 1'b0;
        i_rx_byte            <= 8'd0;
        i_key_buffer_free    <= 8'd0;
        parse_st   = ST_IDLE;
        arg_count  = 4'd0;
        mem_addr   = 8'd0;
        xoff_level = XOFF_THRESHOLD_RST;
        foreach (setting_bytes[k]) setting_bytes[k] = 8'd0;
        foreach (action_hits[k]) action_hits[k] = 0;

        add_row(8'h18,         8'd0,   1, {ACT_REPLY, REPLY_STATUS, 8'h00, 1'b0});
        add_row(8'h18,         8'd1,   1, {ACT_QUEUE, 8'h18, 8'h00, 1'b0});
        add_row(8'hFF,         8'hFF,  1, {ACT_QUEUE, 8'hFF, 8'h00, 1'b0});
        add_row(CMD_STATUS,    8'd41,  1, {ACT_REPLY, REPLY_STATUS | 8'h01, 8'h00, 1'b0});
        add_row(CMD_STATUS,    8'd42,  1, {ACT_REPLY, REPLY_STATUS, 8'h00, 1'b0});
        add_row(CMD_VERSION,   8'd7,   1, {ACT_REPLY, REPLY_VERSION, 8'h00, 1'b0});
        add_row(CMD_CLEAR,     8'd7,   1, {ACT_CLEAR, 8'h00, 8'h00, 1'b0});
        add_row(CMD_NOP_A,     8'd7,   1, {ACT_NONE, 8'h00, 8'h00, 1'b0});
        add_row(CMD_NOP_B,     8'd7,   1, {ACT_NONE, 8'h00, 8'h00, 1'b0});
        add_row(CMD_SPEED,     8'd9,   0, '0);
        add_row(8'h00,         8'd9,   1, {ACT_SPEED, 8'h00, SETTING_SPEED, 1'b1});
        add_row(CMD_KEYMODE,   8'd9,   0, '0);
        add_row(8'hFF,         8'd9,   1, {ACT_MODE, 8'hFF, SETTING_KEYMODE, 1'b1});
        add_row(CMD_PADDLE,    8'd3,   0, '0);
        add_row(PADDLE_DIT,    8'd3,   1, {ACT_DIT, 8'h00, 8'h00, 1'b0});
        add_row(CMD_PADDLE,    8'd3,   0, '0);
        add_row(PADDLE_DAH,    8'd3,   1, {ACT_DAH, 8'h00, 8'h00, 1'b0});
        add_row(CMD_PADDLE,    8'd3,   0, '0);
        add_row(8'h41,         8'd3,   0, '0);
        add_row(CMD_LAST_CODE, 8'd80,  0, '0);
        add_row(8'hAA,         8'd80,  0, '0);
        add_row(CMD_PTT,       8'd80,  0, '0);
        add_row(8'h55,         8'd80,  0, '0);
        add_row(CMD_STATUS,    8'd80,  0, '0);
        add_row(CMD_POT,       8'd0,   0, '0);
        add_row(8'h00,         8'd0,   0, '0);
        add_row(CMD_ADMIN,     8'd0,   0, '0);
        add_row(8'hFF,         8'd0,   0, '0);
        add_row(CMD_ADMIN,     8'd20,  0, '0);
        add_row(ADM_ID,        8'd20,  1, {ACT_REPLY, REPLY_ADMIN2, 8'h00, 1'b0});
        add_row(CMD_ADMIN,     8'd20,  0, '0);
        add_row(ADM_VERSION,   8'd20,  1, {ACT_REPLY, REPLY_ADMIN15, 8'h00, 1'b0});
        add_row(CMD_ADMIN,     8'd20,  0, '0);
        add_row(ADM_ZERO_C,    8'd20,  1, {ACT_REPLY, 8'h00, 8'h00, 1'b0});
        add_row(CMD_ADMIN,     8'd20,  0, '0);
        add_row(ADM_ECHO,      8'd20,  0, '0);
        add_row(8'h5A,         8'd20,  1, {ACT_REPLY, 8'h5A, 8'h00, 1'b0});
        add_row(CMD_ADMIN,     8'd20,  0, '0);
        add_row(ADM_DUMP,      8'd20,  1, {ACT_DUMP, 8'h00, 8'h00, 1'b0});
        add_row(CMD_ADMIN,     8'd20,  0, '0);
        add_row(8'h0B,         8'd20,  0, '0);
        add_row(CMD_ADMIN,     8'd20,  0, '0);
        add_row(ADM_CALIB,     8'd20,  0, '0);
        add_row(CMD_STATUS,    8'd20,  0, '0);
        add_row(CALIB_END,     8'd20,  1, {ACT_NONE, 8'h00, 8'h00, 1'b0});
        add_row(CMD_ADMIN,     8'd20,  0, '0);
        add_row(ADM_RESET,     8'd20,  1, {ACT_RESET, 8'h00, 8'h00, 1'b0});

        repeat (3) @(posedge i_clk);
        i_rst_n <= 1'b1;

        foreach (directed_rows[k]) begin
            send_byte(directed_rows[k].rx, directed_rows[k].free_slots,
                      directed_rows[k].typed, directed_rows[k].res);
        end
        directed_count = items_sent;

        for (phase = 0; phase < PHASES; phase++) begin
            case (phase)
                0: thr = 8'hFF;
                1: thr = 8'h00;
                3: thr = 8'h01;
                5: thr = XOFF_THRESHOLD_RST;
                default: thr = 8'($urandom);
            endcase
            set_xoff_threshold(thr);
            sender_gaps = (phase <= 2);
            sink_stalls = (phase <= 1 || phase == 4);
            if (phase == 0) begin
                send_sequence(SEQ_LOADSET);
                send_sequence(SEQ_LOADMEM);
            end
            if (phase == 1) begin
                long_hold_request = 1'b1;
            end
            phase_goal = directed_count + RANDOM_ITEMS * (phase + 1) / PHASES;
            while (items_sent < phase_goal) begin
                roll = $urandom_range(0, 999);
                if (roll < 4) kind = SEQ_LOADMEM;
                else if (roll < 64) kind = SEQ_LOADSET;
                else if (roll < 79) kind = SEQ_LOADSET_CUT;
                else if (roll < 199) kind = SEQ_ADMIN;
                else if (roll < 289) kind = SEQ_NOISE;
                else if (roll < 369) kind = SEQ_SKIP;
                else if (roll < 439) kind = SEQ_PADDLE;
                else if (roll < 489) kind = SEQ_KEYMODE;
                else if (roll < 539) kind = SEQ_SPEED;
                else if (roll < 599) kind = SEQ_SIMPLE;
                else if (roll < 679) kind = SEQ_STATUS;
                else kind = SEQ_TEXT;
                send_sequence(kind);
            end
        end

        i_in_valid <= 1'b0;
        while (pending_results.size() != 0) @(posedge i_clk);
        repeat (4) @(posedge i_clk);

        kinds = 0;
        foreach (action_hits[k]) kinds += (action_hits[k] != 0);
        $display("Run covered %0d host bytes (%0d from the directed table), %0d results.",
                 items_sent, directed_count, results_seen);
        $display("Threshold written %0d times; %0d result actions seen, %0d memory writes.",
                 cfg_writes, kinds, action_hits[ACT_MEMWR]);
        if (error_count == 0) begin
            $display("keyer_host_command_parser_test: done, clean");
        end else begin
            $display("keyer_host_command_parser_test: done, errors");
        end
        $finish;
    end

endmodule

>>> files.f
design/kchp_pkg.sv
design/kchp_decode.sv
design/keyer_host_command_parser.sv
design/kchp_checker.sv
dv/keyer_host_command_parser_test.sv
